// ----- rtl/core/mfp_pkg.sv -----
// shared types and codes for the message frame parser
// no dependencies; imported by the interfaces' users and all parser modules
package mfp_pkg;

   // parse phases, which double as the field kind codes 0 to 7
   localparam logic [3:0] PH_TYPE   = 4'd0;
   localparam logic [3:0] PH_ADDR   = 4'd1;
   localparam logic [3:0] PH_COUNT  = 4'd2;
   localparam logic [3:0] PH_TARGET = 4'd3;
   localparam logic [3:0] PH_ETYPE  = 4'd4;
   localparam logic [3:0] PH_SIZE   = 4'd5;
   localparam logic [3:0] PH_DATA   = 4'd6;
   localparam logic [3:0] PH_IGNORE = 4'd7;

   // field kinds
   localparam logic [2:0] KIND_TYPE    = 3'd0;
   localparam logic [2:0] KIND_ADDR    = 3'd1;
   localparam logic [2:0] KIND_COUNT   = 3'd2;
   localparam logic [2:0] KIND_TARGET  = 3'd3;
   localparam logic [2:0] KIND_ETYPE   = 3'd4;
   localparam logic [2:0] KIND_SIZE    = 3'd5;
   localparam logic [2:0] KIND_DATA    = 3'd6;
   localparam logic [2:0] KIND_IGNORED = 3'd7;

   // index of the last address byte
   localparam logic [2:0] LAST_ADDR_POS = 3'd5;

   // frame status codes
   localparam logic [1:0] ST_PENDING   = 2'd0;
   localparam logic [1:0] ST_OK        = 2'd1;
   localparam logic [1:0] ST_SHORT     = 2'd2;
   localparam logic [1:0] ST_TRUNCATED = 2'd3;

   // one input item
   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_end;
   } req_item_type;

   // one result item
   typedef struct packed {
      logic [2:0] field_kind;
      logic [7:0] field_value;
      logic [7:0] field_offset;
      logic [7:0] entry_number;
      logic       entry_done;
      logic       frame_done;
      logic [1:0] frame_status;
   } rsp_item_type;

endpackage

// ----- rtl/core/mfp_channels.sv -----
// valid/ready channel interfaces for the message frame parser
// no dependencies; the byte channel and the tagged result channel
interface mfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_end;

   modport source (output valid, data_byte, frame_end, input ready);
   modport sink   (input valid, data_byte, frame_end, output ready);
endinterface

interface mfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] field_kind;
   logic [7:0] field_value;
   logic [7:0] field_offset;
   logic [7:0] entry_number;
   logic       entry_done;
   logic       frame_done;
   logic [1:0] frame_status;

   modport source (output valid, field_kind, field_value, field_offset, entry_number,
                   entry_done, frame_done, frame_status, input ready);
   modport sink   (input valid, field_kind, field_value, field_offset, entry_number,
                   entry_done, frame_done, frame_status, output ready);
endinterface

// ----- rtl/core/mfp_in_reg.sv -----
// input register stage of the message frame parser
// depends on mfp_pkg for the input item type
module mfp_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  mfp_pkg::req_item_type in_item,
   input  logic                  take,
   output logic                  held_valid,
   output mfp_pkg::req_item_type held_item
);
   import mfp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   // free when empty or when the held item moves on this cycle
   assign in_ready = !valid_ff || take;
   assign valid_in = (in_valid && in_ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

// ----- rtl/core/mfp_parse_core.sv -----
// frame parser state and per-byte tagging logic
// depends on mfp_pkg for phase, kind and status codes and item types
module mfp_parse_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  mfp_pkg::req_item_type item,
   output mfp_pkg::rsp_item_type result
);
   import mfp_pkg::*;

   logic [3:0] phase_ff,       phase_in;
   logic [2:0] header_pos_ff,  header_pos_in;
   logic [7:0] entries_rem_ff, entries_rem_in;
   logic [7:0] data_rem_ff,    data_rem_in;
   logic [7:0] cur_entry_ff,   cur_entry_in;
   logic [7:0] data_pos_ff,    data_pos_in;

   logic [7:0] entries_dec;
   logic [7:0] data_dec;
   logic       finish;

   assign entries_dec = entries_rem_ff - 8'd1;
   assign data_dec    = data_rem_ff - 8'd1;

   // tag the byte and work out the next state
   always_comb begin
      phase_in       = phase_ff;
      header_pos_in  = header_pos_ff;
      entries_rem_in = entries_rem_ff;
      data_rem_in    = data_rem_ff;
      cur_entry_in   = cur_entry_ff;
      data_pos_in    = data_pos_ff;
      finish         = 1'b0;

      result.field_kind   = KIND_IGNORED;
      result.field_value  = item.data_byte;
      result.field_offset = 8'd0;
      result.entry_number = 8'd0;
      result.entry_done   = 1'b0;
      result.frame_done   = 1'b0;
      result.frame_status = ST_PENDING;

      unique case (phase_ff)
         PH_TYPE: begin
            result.field_kind = KIND_TYPE;
            header_pos_in     = 3'd0;
            phase_in          = PH_ADDR;
         end
         PH_ADDR: begin
            result.field_kind   = KIND_ADDR;
            result.field_offset = {5'd0, header_pos_ff};
            if (header_pos_ff >= LAST_ADDR_POS) begin
               phase_in = PH_COUNT;
            end else begin
               header_pos_in = header_pos_ff + 3'd1;
            end
         end
         PH_COUNT: begin
            result.field_kind = KIND_COUNT;
            entries_rem_in    = item.data_byte;
            cur_entry_in      = 8'd0;
            if (item.data_byte == 8'd0) begin
               result.frame_done = 1'b1;
               phase_in          = PH_IGNORE;
            end else begin
               phase_in = PH_TARGET;
            end
         end
         PH_TARGET: begin
            result.field_kind   = KIND_TARGET;
            result.entry_number = cur_entry_ff;
            phase_in            = PH_ETYPE;
         end
         PH_ETYPE: begin
            result.field_kind   = KIND_ETYPE;
            result.entry_number = cur_entry_ff;
            phase_in            = PH_SIZE;
         end
         PH_SIZE: begin
            result.field_kind   = KIND_SIZE;
            result.entry_number = cur_entry_ff;
            data_rem_in         = item.data_byte;
            data_pos_in         = 8'd0;
            if (item.data_byte == 8'd0) begin
               finish = 1'b1;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            result.field_kind   = KIND_DATA;
            result.entry_number = cur_entry_ff;
            result.field_offset = data_pos_ff;
            data_pos_in         = data_pos_ff + 8'd1;
            data_rem_in         = data_dec;
            finish              = (data_dec == 8'd0);
         end
         default: begin
            result.field_kind = KIND_IGNORED;
            phase_in          = PH_IGNORE;
         end
      endcase

      // entry complete: step to the next entry or to the trailing bytes
      if (finish) begin
         result.entry_done = 1'b1;
         entries_rem_in    = entries_dec;
         if (entries_dec == 8'd0) begin
            result.frame_done = 1'b1;
            phase_in          = PH_IGNORE;
         end else begin
            cur_entry_in = cur_entry_ff + 8'd1;
            phase_in     = PH_TARGET;
         end
      end

      // final byte: report status and start over
      if (item.frame_end) begin
         if (phase_ff == PH_TYPE || phase_ff == PH_ADDR) begin
            result.frame_status = ST_SHORT;
         end else if (result.frame_done || phase_ff >= PH_IGNORE) begin
            result.frame_status = ST_OK;
         end else begin
            result.frame_status = ST_TRUNCATED;
         end
         phase_in       = PH_TYPE;
         header_pos_in  = 3'd0;
         entries_rem_in = 8'd0;
         data_rem_in    = 8'd0;
         cur_entry_in   = 8'd0;
         data_pos_in    = 8'd0;
      end
   end

   // parser state, updated when a byte moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_TYPE;
         header_pos_ff  <= 3'd0;
         entries_rem_ff <= 8'd0;
         data_rem_ff    <= 8'd0;
         cur_entry_ff   <= 8'd0;
         data_pos_ff    <= 8'd0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         header_pos_ff  <= header_pos_in;
         entries_rem_ff <= entries_rem_in;
         data_rem_ff    <= data_rem_in;
         cur_entry_ff   <= cur_entry_in;
         data_pos_ff    <= data_pos_in;
      end
   end

   // a final byte always leaves the parser waiting for a type byte
   a_restart: assert property (@(posedge clock) disable iff (reset)
      advance && item.frame_end |=> phase_ff == PH_TYPE)
      else $error("parser did not restart after final byte");

   // status only on the final byte
   a_status_final: assert property (@(posedge clock) disable iff (reset)
      advance && !item.frame_end |-> result.frame_status == ST_PENDING)
      else $error("status on a byte that is not final");

   // entry end only on a size or data byte
   a_entry_kind: assert property (@(posedge clock) disable iff (reset)
      advance && result.entry_done |->
         (result.field_kind == KIND_SIZE || result.field_kind == KIND_DATA))
      else $error("entry end on wrong field kind");

   // frame end is followed by trailing bytes unless the frame closes
   a_frame_done: assert property (@(posedge clock) disable iff (reset)
      advance && result.frame_done && !item.frame_end |=> phase_ff == PH_IGNORE)
      else $error("frame end did not move to trailing bytes");

endmodule

// ----- rtl/core/message_frame_parser.sv -----
// message frame parser: an accepted byte becomes a result item by way of the
// input register, then tagging logic into the result register
// one item per cycle unless output stalls; each byte costs one phase update
// reset is synchronous and active high: clears both stage valids and returns
// the parser to waiting for a message type byte
module message_frame_parser (
   input  logic              clock,
   input  logic              reset,
   mfp_req_if.sink           req_ch,
   mfp_rsp_if.source         rsp_ch
);
   import mfp_pkg::*;

   req_item_type req_item;
   req_item_type held_item;
   rsp_item_type tag_out;
   rsp_item_type rsp_item_ff;
   logic         held_valid;
   logic         advance;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic         out_free;

   assign req_item.data_byte = req_ch.data_byte;
   assign req_item.frame_end = req_ch.frame_end;

   // result register is free when empty or being taken
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign advance  = held_valid && out_free;

   mfp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .in_item    (req_item),
      .take       (advance),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   mfp_parse_core u_parse (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (held_item),
      .result  (tag_out)
   );

   // result register
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= tag_out;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.field_kind   = rsp_item_ff.field_kind;
   assign rsp_ch.field_value  = rsp_item_ff.field_value;
   assign rsp_ch.field_offset = rsp_item_ff.field_offset;
   assign rsp_ch.entry_number = rsp_item_ff.entry_number;
   assign rsp_ch.entry_done   = rsp_item_ff.entry_done;
   assign rsp_ch.frame_done   = rsp_item_ff.frame_done;
   assign rsp_ch.frame_status = rsp_item_ff.frame_status;

endmodule

// ----- tb/sv/message_frame_parser_test.sv -----
// self-checking bench for message_frame_parser: byte frames in, tagged items out
// depends on mfp_pkg and the mfp_req_if / mfp_rsp_if channel interfaces
// predicts every tag from its own parser model and checks items in order
module message_frame_parser_test;
   import mfp_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 300000;
   localparam int unsigned BYTE_TARGET  = 1550;
   localparam int unsigned CALM_TAIL    = 150;
   localparam int unsigned HOLD_CYCLES  = 80;
   localparam int unsigned DRAIN_CYCLES = 8;

   typedef enum {CUT_NONE, CUT_SHORT, CUT_TRUNC} frame_cut_type;

   logic clock;
   logic reset;

   mfp_req_if req_ch();
   mfp_rsp_if rsp_ch();

   message_frame_parser dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   req_item_type bytes_to_send[$];
   rsp_item_type tags_due[$];
   int unsigned  bytes_accepted = 0;
   int unsigned  mismatch_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  send_gap = 0;
   int unsigned  send_quiet = 0;
   int unsigned  take_gap = 0;
   int unsigned  take_quiet = 0;
   logic         long_hold;

   // parser state as the bench sees it
   logic [3:0] parse_at;
   logic [2:0] addr_at;
   logic [7:0] entries_left;
   logic [7:0] data_left;
   logic [7:0] entry_at;
   logic [7:0] data_at;

   // clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_parser();
      parse_at     = PH_TYPE;
      addr_at      = 3'd0;
      entries_left = 8'd0;
      data_left    = 8'd0;
      entry_at     = 8'd0;
      data_at      = 8'd0;
   endfunction

   // tag one accepted byte and advance the parser state
   function automatic rsp_item_type tag_byte(input logic [7:0] b, input logic last);
      rsp_item_type t;
      logic [3:0]   seen;
      seen          = parse_at;
      t             = '0;
      t.field_kind  = seen[2:0];
      t.field_value = b;
      case (seen)
         PH_TYPE: begin
            addr_at  = 3'd0;
            parse_at = PH_ADDR;
         end
         PH_ADDR: begin
            t.field_offset = {5'd0, addr_at};
            if (addr_at >= LAST_ADDR_POS) parse_at = PH_COUNT;
            else addr_at = addr_at + 3'd1;
         end
         PH_COUNT: begin
            entries_left = b;
            entry_at     = 8'd0;
            if (b == 8'd0) begin
               t.frame_done = 1'b1;
               parse_at     = PH_IGNORE;
            end else begin
               parse_at = PH_TARGET;
            end
         end
         PH_TARGET: begin
            t.entry_number = entry_at;
            parse_at       = PH_ETYPE;
         end
         PH_ETYPE: begin
            t.entry_number = entry_at;
            parse_at       = PH_SIZE;
         end
         PH_SIZE: begin
            t.entry_number = entry_at;
            data_left      = b;
            data_at        = 8'd0;
            if (b == 8'd0) t.entry_done = 1'b1;
            else parse_at = PH_DATA;
         end
         PH_DATA: begin
            t.entry_number = entry_at;
            t.field_offset = data_at;
            data_at        = data_at + 8'd1;
            data_left      = data_left - 8'd1;
            if (data_left == 8'd0) t.entry_done = 1'b1;
         end
         default: begin
            t.field_kind = KIND_IGNORED;
            parse_at     = PH_IGNORE;
         end
      endcase
      // entry complete: move to the next entry or to the trailing bytes
      if (t.entry_done) begin
         entries_left = entries_left - 8'd1;
         if (entries_left == 8'd0) begin
            t.frame_done = 1'b1;
            parse_at     = PH_IGNORE;
         end else begin
            entry_at = entry_at + 8'd1;
            parse_at = PH_TARGET;
         end
      end
      // final byte decides the status and starts the next frame afresh
      if (last) begin
         if (seen == PH_TYPE || seen == PH_ADDR) t.frame_status = ST_SHORT;
         else if (t.frame_done || seen >= PH_IGNORE) t.frame_status = ST_OK;
         else t.frame_status = ST_TRUNCATED;
         clear_parser();
      end
      return t;
   endfunction

   function automatic bit winding_down();
      return bytes_to_send.size() < CALM_TAIL;
   endfunction

   function automatic string show(input rsp_item_type t);
      return $sformatf("kind %0d value %02h offset %0d entry %0d edone %0b fdone %0b status %0d",
                       t.field_kind, t.field_value, t.field_offset, t.entry_number,
                       t.entry_done, t.frame_done, t.frame_status);
   endfunction

   task automatic note_fault(input string what, input rsp_item_type want,
                             input rsp_item_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s\n   expected %s\n   actual   %s", what, show(want), show(got));
   endtask

   task automatic add_byte(input logic [7:0] b, input bit last);
      req_item_type it;
      it.data_byte = b;
      it.frame_end = last;
      bytes_to_send = {bytes_to_send, it};
   endtask

   // build one frame with random content; the cut decides where it ends
   task automatic add_frame(input int unsigned count, input int unsigned max_size,
                            input int big_entry, input frame_cut_type cut);
      logic [7:0]  body[$];
      int unsigned size;
      int unsigned done_at;
      int unsigned last_at;
      int unsigned trail;
      body = {body, 8'($urandom_range(0, 255))};
      repeat (6) body = {body, 8'($urandom_range(0, 255))};
      body = {body, count[7:0]};
      for (int e = 0; e < int'(count); e++) begin
         size = (e == big_entry) ? 255 : $urandom_range(0, max_size);
         body = {body, 8'($urandom_range(0, 255))};
         body = {body, 8'($urandom_range(0, 255))};
         body = {body, size[7:0]};
         repeat (size) body = {body, 8'($urandom_range(0, 255))};
      end
      done_at = body.size() - 1;
      case (cut)
         CUT_SHORT: last_at = $urandom_range(0, 6);
         CUT_TRUNC: begin
            if (done_at > 7) last_at = $urandom_range(7, (done_at - 1 < 60) ? done_at - 1 : 60);
            else last_at = done_at;
         end
         default: begin
            trail = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
            repeat (trail) body = {body, 8'($urandom_range(0, 255))};
            last_at = body.size() - 1;
         end
      endcase
      for (int i = 0; i <= int'(last_at); i++) add_byte(body[i], i == int'(last_at));
   endtask

   // sender: offers queued bytes, idles in bursts, predicts each accepted item
   always @(posedge clock) begin
      req_item_type next_byte;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            tags_due = {tags_due, tag_byte(req_ch.data_byte, req_ch.frame_end)};
            bytes_accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (!winding_down() && send_quiet == 0 && $urandom_range(0, 19) < 3) begin
               send_gap = $urandom_range(0, 12);
               req_ch.valid <= 1'b0;
            end else if (bytes_to_send.size() != 0) begin
               if (send_quiet > 0) send_quiet--;
               else if ($urandom_range(0, 19) == 0) send_quiet = $urandom_range(20, 100);
               next_byte = bytes_to_send.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.data_byte <= next_byte.data_byte;
               req_ch.frame_end <= next_byte.frame_end;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each accepted item against the oldest prediction
   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.field_kind   = rsp_ch.field_kind;
            got.field_value  = rsp_ch.field_value;
            got.field_offset = rsp_ch.field_offset;
            got.entry_number = rsp_ch.entry_number;
            got.entry_done   = rsp_ch.entry_done;
            got.frame_done   = rsp_ch.frame_done;
            got.frame_status = rsp_ch.frame_status;
            if (tags_due.size() == 0) begin
               note_fault("item with nothing predicted", '0, got);
            end else begin
               want = tags_due.pop_front();
               if (got.field_kind !== want.field_kind || got.field_value !== want.field_value ||
                   got.field_offset !== want.field_offset ||
                   got.entry_number !== want.entry_number ||
                   got.entry_done !== want.entry_done || got.frame_done !== want.frame_done ||
                   got.frame_status !== want.frame_status)
                  note_fault("tag mismatch", want, got);
            end
         end
         if (long_hold) begin
            rsp_ch.ready <= 1'b0;
         end else if (take_gap > 0) begin
            take_gap--;
            rsp_ch.ready <= 1'b0;
         end else if (!winding_down() && take_quiet == 0 && $urandom_range(0, 19) < 3) begin
            take_gap = $urandom_range(0, 12);
            rsp_ch.ready <= 1'b0;
         end else begin
            if (take_quiet > 0) take_quiet--;
            else if ($urandom_range(0, 19) == 0) take_quiet = $urandom_range(20, 100);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // one long receiver hold-off so the pipeline fills and backs up the input
   initial begin
      long_hold = 1'b0;
      do @(posedge clock); while (bytes_accepted < 200);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // stimulus, reset and end of run
   initial begin
      int unsigned   total_bytes;
      int unsigned   count;
      bit            big_done;
      frame_cut_type cut;
      int unsigned   roll;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = 8'd0;
      req_ch.frame_end = 1'b0;
      rsp_ch.ready     = 1'b0;
      big_done         = 1'b0;
      clear_parser();

      // short frame: a lone type byte
      add_byte(8'hFF, 1'b1);
      // complete frame, empty entry then two data bytes, one trailing byte
      add_byte(8'h00, 1'b0);
      for (int i = 0; i < 6; i++) add_byte(i[0] ? 8'hFF : 8'h00, 1'b0);
      add_byte(8'd2, 1'b0);
      add_byte(8'hA5, 1'b0);
      add_byte(8'h5A, 1'b0);
      add_byte(8'd0, 1'b0);
      add_byte(8'h01, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'd2, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'h7E, 1'b1);
      // truncated on the count byte, largest count
      add_byte(8'h55, 1'b0);
      repeat (6) add_byte(8'hAA, 1'b0);
      add_byte(8'hFF, 1'b1);

      // random frames, mostly well formed; one frame of 255 entries with a full-size entry
      while (bytes_to_send.size() < BYTE_TARGET) begin
         if (!big_done && bytes_to_send.size() >= 300) begin
            add_frame(255, 0, $urandom_range(150, 254), CUT_NONE);
            big_done = 1'b1;
         end else begin
            roll  = $urandom_range(0, 19);
            count = $urandom_range(0, 4);
            if (roll < 2) cut = CUT_SHORT;
            else if (roll < 5) cut = CUT_TRUNC;
            else cut = CUT_NONE;
            if (roll == 2) count = $urandom_range(5, 255);
            add_frame(count, ($urandom_range(0, 9) == 0) ? 40 : 6, -1, cut);
         end
      end
      total_bytes = bytes_to_send.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (bytes_accepted != total_bytes || tags_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tags_due.size() != 0) $display("%0d predicted items never arrived", tags_due.size());
      if (mismatch_count == 0 && tags_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
